// ===== rtl/imu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_pkg: shared types and constants
// Fixed-point constants, CORDIC angle table, controller states and the
// command bundle between controller and datapath.
// ----------------------------------------------------------------------------
package imu_pkg;

  localparam int CORDIC_ITERATIONS = 16;
  localparam int ATAN_ENTRIES      = 24;
  localparam int CORDIC_STEPS      =
    (CORDIC_ITERATIONS < ATAN_ENTRIES) ? CORDIC_ITERATIONS : ATAN_ENTRIES;

  localparam int CNT_W       = 5;
  localparam int SQRT_STEPS  = 30;   // root bits of a 60-bit radicand
  localparam int RUN_STEPS   = SQRT_STEPS;  // yaw readout and roll finish earlier
  localparam int SCALE_N     = 6;    // three rates, three accelerations

  localparam int CW    = 34;         // CORDIC x/y width
  localparam int ZW    = 24;         // CORDIC angle accumulator width
  localparam int ANG_W = 15;

  localparam int ACC_W  = 49;        // yaw accumulator
  localparam int SUM_W  = 52;        // accumulator plus one step
  localparam int PROD_W = 49;        // gyro z times elapsed time

  localparam logic signed [SUM_W-1:0] YAW_MAX = 52'sd275146342271875;
  localparam logic signed [SUM_W-1:0] YAW_MIN = -52'sd275146342400000;
  localparam logic [16:0] YAW_DIV = 17'd128125;
  localparam logic [31:0] M_YAW   = 32'd2196877867;  // floor(2^48 / 128125)

  localparam logic signed [ZW-1:0] Z_QUARTER   = 24'sd1474560;
  localparam logic signed [ZW-1:0] ANGLE_LIMIT = 24'sd11520;

  // reciprocals for round-to-nearest scaling
  localparam logic [25:0] M_GYRO  = 26'd3273604;   // 2^27 / 41
  localparam logic [25:0] M_ACCEL = 26'd42949673;  // 2^36 / 1600

  localparam logic signed [16:0] TEMP_OFFSET = 17'sd11776;

  localparam logic REG_DEADZONE = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_ACC, ST_INIT, ST_RUN, ST_PINIT, ST_PITCH, ST_DONE
  } state_t;

  typedef struct packed {
    logic             load;
    logic             clr;
    logic             mul;
    logic             acc;
    logic             init;
    logic             run_step;
    logic             pinit;
    logic             pitch_step;
    logic             out_load;
    logic [CNT_W-1:0] cnt;
  } dp_cmd_t;

  typedef struct packed {
    logic signed [15:0] gyro_x_raw;
    logic signed [15:0] gyro_y_raw;
    logic signed [15:0] gyro_z_raw;
    logic signed [15:0] accel_x_raw;
    logic signed [15:0] accel_y_raw;
    logic signed [15:0] accel_z_raw;
    logic signed [15:0] temp_raw;
    logic [31:0]        elapsed_us;
  } sample_t;

  typedef struct packed {
    logic signed [15:0]      rate_x;
    logic signed [15:0]      rate_y;
    logic signed [15:0]      rate_z;
    logic signed [15:0]      accel_x_ms2;
    logic signed [15:0]      accel_y_ms2;
    logic signed [15:0]      accel_z_ms2;
    logic signed [ANG_W-1:0] roll_angle;
    logic signed [ANG_W-1:0] pitch_angle;
    logic signed [31:0]      yaw_angle;
    logic signed [16:0]      temperature;
  } result_t;

  // arctangent of 2^-i in 1/16384 degree
  function automatic logic signed [ZW-1:0] atan_at(input logic [CNT_W-1:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:    v = 24'sd737280;
      5'd1:    v = 24'sd435240;
      5'd2:    v = 24'sd229971;
      5'd3:    v = 24'sd116736;
      5'd4:    v = 24'sd58595;
      5'd5:    v = 24'sd29326;
      5'd6:    v = 24'sd14667;
      5'd7:    v = 24'sd7334;
      5'd8:    v = 24'sd3667;
      5'd9:    v = 24'sd1833;
      5'd10:   v = 24'sd917;
      5'd11:   v = 24'sd458;
      5'd12:   v = 24'sd229;
      5'd13:   v = 24'sd115;
      5'd14:   v = 24'sd57;
      5'd15:   v = 24'sd29;
      5'd16:   v = 24'sd14;
      5'd17:   v = 24'sd7;
      5'd18:   v = 24'sd4;
      5'd19:   v = 24'sd2;
      5'd20:   v = 24'sd1;
      default: v = 24'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/imu_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_ctrl: sequencer
// Walks each sample through yaw update, shared iteration phase, pitch
// CORDIC and the output register.
// ----------------------------------------------------------------------------
module imu_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  input  logic             in_kind,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output imu_pkg::dp_cmd_t cmd
);
  import imu_pkg::*;

  localparam logic [CNT_W-1:0] RUN_LAST   = CNT_W'(RUN_STEPS - 1);
  localparam logic [CNT_W-1:0] PITCH_LAST = CNT_W'(CORDIC_STEPS - 1);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    in_tready     = 1'b0;
    cmd           = '0;
    cmd.cnt       = cnt_r;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load = 1'b1;
          if (in_kind) cmd.clr = 1'b1;
          else state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        cmd.acc   = 1'b1;
        state_nxt = ST_INIT;
      end
      ST_INIT: begin
        cmd.init  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        cmd.run_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == RUN_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_PINIT;
        end
      end
      ST_PINIT: begin
        cmd.pinit = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_PITCH;
      end
      ST_PITCH: begin
        cmd.pitch_step = 1'b1;
        cnt_nxt        = cnt_r + 1'b1;
        if (cnt_r == PITCH_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_tready))
    else $error("output overwritten while held");
  a_sample_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && !in_kind) |=> (state_r == ST_MUL))
    else $error("sample request did not start processing");
  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && cnt_r == RUN_LAST) |=> (state_r == ST_PINIT && cnt_r == '0))
    else $error("run phase did not hand over to pitch");
  a_pitch_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PITCH) |-> (cnt_r < CNT_W'(CORDIC_STEPS)))
    else $error("pitch iteration count out of range");
`endif

endmodule

// ===== rtl/imu_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_cordic: vectoring CORDIC, one iteration per step
// Returns atan2(y, x) in 1/64 degree, clamped to +-180 degrees.
// ----------------------------------------------------------------------------
module imu_cordic (
  input  logic                             clk,
  input  logic                             start,
  input  logic                             step,
  input  logic [imu_pkg::CNT_W-1:0]        idx,
  input  logic signed [imu_pkg::CW-1:0]    y_in,
  input  logic signed [imu_pkg::CW-1:0]    x_in,
  output logic signed [imu_pkg::ANG_W-1:0] angle
);
  import imu_pkg::*;

  logic signed [CW-1:0] x_r, y_r, xs, ys;
  logic signed [ZW-1:0] z_r, zr, zs;
  logic                 zero_r;

  assign xs = x_r >>> idx;
  assign ys = y_r >>> idx;

  always_ff @(posedge clk) begin
    if (start) begin
      zero_r <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        if (y_in >= 0) begin
          x_r <= y_in;
          y_r <= -x_in;
          z_r <= Z_QUARTER;
        end else begin
          x_r <= -y_in;
          y_r <= x_in;
          z_r <= -Z_QUARTER;
        end
      end else begin
        x_r <= x_in;
        y_r <= y_in;
        z_r <= '0;
      end
    end else if (step) begin
      if (y_r >= 0) begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + atan_at(idx);
      end else begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - atan_at(idx);
      end
    end
  end

  // round to nearest 1/64 degree, halves upward
  assign zr = z_r + 24'sd128;
  assign zs = zr >>> 8;

  always_comb begin
    if (zero_r)                 angle = '0;
    else if (zs > ANGLE_LIMIT)  angle = ANG_W'(ANGLE_LIMIT);
    else if (zs < -ANGLE_LIMIT) angle = ANG_W'(-ANGLE_LIMIT);
    else                        angle = ANG_W'(zs);
  end

endmodule

// ===== rtl/imu_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_dp: datapath
// Unit scaling, yaw accumulator with saturation, serial square root,
// reciprocal-multiply yaw readout, shared CORDIC and result register.
// ----------------------------------------------------------------------------
module imu_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  imu_pkg::dp_cmd_t  cmd,
  input  imu_pkg::sample_t  smp,
  input  logic [14:0]       deadzone,
  output imu_pkg::result_t  res
);
  import imu_pkg::*;

  sample_t                 s_r;
  result_t                 res_r;

  // yaw
  logic signed [PROD_W-1:0] yprod_r;
  logic                     yaw_en_r;
  logic signed [ACC_W-1:0]  accum_r;
  logic signed [SUM_W-1:0]  ysum, ysat;
  logic [15:0]              gz_mag;

  // square root
  logic [30:0]  ay2_r, az2_r;
  logic [31:0]  sq_sum;
  logic [59:0]  sq_v_r;
  logic [32:0]  sq_rem_r, sq_rs, sq_trial;
  logic [29:0]  sq_root_r;

  // yaw readout: |accum| / 128125 by reciprocal, 16 bits of |accum| a step
  logic [ACC_W-2:0] acc_mag;
  logic [47:0]      dv_mag_r;
  logic [15:0]      dv_chunk;
  logic [47:0]      dv_pp;
  logic [48:0]      dv_acc_r;
  logic [47:0]      dv_qd, dv_qd_r, dv_rem;
  logic [31:0]      dv_q_r;
  logic             dv_neg_r;

  // scaling
  logic signed [15:0] sc_raw;
  logic [15:0]        sc_mag;
  logic [24:0]        sc_num_r, sc_num;
  logic               sc_neg_r, sc_acc_r, sc_acc;
  logic [50:0]        sc_prod;
  logic [14:0]        sc_q;
  logic signed [15:0] scaled_r [SCALE_N];
  logic [2:0]         sc_widx;

  // CORDIC
  logic signed [CW-1:0]    cx, cy;
  logic signed [16:0]      nax;
  logic                    c_step;
  logic signed [ANG_W-1:0] c_angle, roll_r;

  // ---------------- yaw accumulator
  assign gz_mag = s_r.gyro_z_raw[15] ? 16'(-s_r.gyro_z_raw) : 16'(s_r.gyro_z_raw);
  assign ysum   = SUM_W'(accum_r) + (SUM_W'(yprod_r) <<< 3);
  always_comb begin
    if (ysum > YAW_MAX)      ysat = YAW_MAX;
    else if (ysum < YAW_MIN) ysat = YAW_MIN;
    else                     ysat = ysum;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r <= '0;
    end else if (cmd.clr) begin
      accum_r <= '0;
    end else if (cmd.acc && yaw_en_r) begin
      accum_r <= ACC_W'(ysat);
    end
  end

  // ---------------- helpers
  assign sq_sum   = 32'(ay2_r) + 32'(az2_r);
  assign sq_rs    = {sq_rem_r[30:0], sq_v_r[59:58]};
  assign sq_trial = {1'b0, sq_root_r, 2'b01};
  assign acc_mag  = accum_r[ACC_W-1] ? (ACC_W-1)'(-accum_r) : (ACC_W-1)'(accum_r);

  // quotient estimate is at most one low; one remainder check settles it
  always_comb begin
    case (cmd.cnt[1:0])
      2'd0:    dv_chunk = dv_mag_r[15:0];
      2'd1:    dv_chunk = dv_mag_r[31:16];
      default: dv_chunk = dv_mag_r[47:32];
    endcase
  end
  assign dv_pp  = 48'(dv_chunk) * 48'(M_YAW);
  assign dv_qd  = 48'(dv_q_r) * 48'(YAW_DIV);
  assign dv_rem = dv_mag_r - dv_qd_r;

  always_comb begin
    case (cmd.cnt[2:0])
      3'd0:    sc_raw = s_r.gyro_x_raw;
      3'd1:    sc_raw = s_r.gyro_y_raw;
      3'd2:    sc_raw = s_r.gyro_z_raw;
      3'd3:    sc_raw = s_r.accel_x_raw;
      3'd4:    sc_raw = s_r.accel_y_raw;
      default: sc_raw = s_r.accel_z_raw;
    endcase
  end
  assign sc_acc  = (cmd.cnt >= CNT_W'(3));
  assign sc_mag  = sc_raw[15] ? 16'(-sc_raw) : 16'(sc_raw);
  assign sc_num  = sc_acc ? (25'(sc_mag) * 25'd981 + 25'd800)
                          : (25'(sc_mag) * 25'd40 + 25'd20);
  assign sc_prod = 51'(sc_num_r) * 51'(sc_acc_r ? M_ACCEL : M_GYRO);
  assign sc_q    = sc_acc_r ? sc_prod[50:36] : sc_prod[41:27];
  assign sc_widx = 3'(cmd.cnt - 1'b1);

  // ---------------- CORDIC operands
  assign nax = -17'(s_r.accel_x_raw);
  assign cy  = cmd.pinit ? {{3{nax[16]}}, nax, 14'b0}
                         : {{4{s_r.accel_y_raw[15]}}, s_r.accel_y_raw, 14'b0};
  assign cx  = cmd.pinit ? {4'b0, sq_root_r}
                         : {{4{s_r.accel_z_raw[15]}}, s_r.accel_z_raw, 14'b0};
  assign c_step = (cmd.run_step && (cmd.cnt < CNT_W'(CORDIC_STEPS))) || cmd.pitch_step;

  imu_cordic u_cordic (
    .clk   (clk),
    .start (cmd.init || cmd.pinit),
    .step  (c_step),
    .idx   (cmd.cnt),
    .y_in  (cy),
    .x_in  (cx),
    .angle (c_angle)
  );

  // ---------------- sequenced registers
  always_ff @(posedge clk) begin
    if (cmd.load) s_r <= smp;

    if (cmd.mul) begin
      yprod_r  <= PROD_W'($signed(s_r.gyro_z_raw)) * $signed(PROD_W'({1'b0, s_r.elapsed_us}));
      yaw_en_r <= gz_mag > {1'b0, deadzone};
      ay2_r    <= 31'($signed(s_r.accel_y_raw) * $signed(s_r.accel_y_raw));
      az2_r    <= 31'($signed(s_r.accel_z_raw) * $signed(s_r.accel_z_raw));
    end

    if (cmd.init) begin
      sq_v_r    <= {sq_sum, 28'b0};
      sq_rem_r  <= '0;
      sq_root_r <= '0;
      dv_mag_r  <= acc_mag;
      dv_neg_r  <= accum_r[ACC_W-1];
    end

    if (cmd.run_step) begin
      if (cmd.cnt < CNT_W'(SQRT_STEPS)) begin
        sq_v_r <= {sq_v_r[57:0], 2'b00};
        if (sq_rs >= sq_trial) begin
          sq_rem_r  <= sq_rs - sq_trial;
          sq_root_r <= {sq_root_r[28:0], 1'b1};
        end else begin
          sq_rem_r  <= sq_rs;
          sq_root_r <= {sq_root_r[28:0], 1'b0};
        end
      end
      // steps 0-2: partial products, low chunk first; 3: estimate;
      // 4: estimate times divisor; 5: correct by one
      if (cmd.cnt == CNT_W'(0)) begin
        dv_acc_r <= 49'(dv_pp);
      end else if (cmd.cnt <= CNT_W'(2)) begin
        dv_acc_r <= (dv_acc_r >> 16) + 49'(dv_pp);
      end
      if (cmd.cnt == CNT_W'(3)) dv_q_r <= dv_acc_r[47:16];
      if (cmd.cnt == CNT_W'(4)) dv_qd_r <= dv_qd;
      if (cmd.cnt == CNT_W'(5) && dv_rem >= 48'(YAW_DIV)) dv_q_r <= dv_q_r + 1'b1;
      if (cmd.cnt < CNT_W'(SCALE_N)) begin
        sc_num_r <= sc_num;
        sc_neg_r <= sc_raw[15];
        sc_acc_r <= sc_acc;
      end
      if (cmd.cnt >= CNT_W'(1) && cmd.cnt <= CNT_W'(SCALE_N)) begin
        scaled_r[sc_widx] <= sc_neg_r ? -$signed({1'b0, sc_q}) : $signed({1'b0, sc_q});
      end
    end

    if (cmd.pinit) roll_r <= c_angle;

    if (cmd.out_load) begin
      res_r.rate_x      <= scaled_r[0];
      res_r.rate_y      <= scaled_r[1];
      res_r.rate_z      <= scaled_r[2];
      res_r.accel_x_ms2 <= scaled_r[3];
      res_r.accel_y_ms2 <= scaled_r[4];
      res_r.accel_z_ms2 <= scaled_r[5];
      res_r.roll_angle  <= roll_r;
      res_r.pitch_angle <= c_angle;
      res_r.yaw_angle   <= dv_neg_r ? -$signed(dv_q_r) : $signed(dv_q_r);
      res_r.temperature <= TEMP_OFFSET + 17'(s_r.temp_raw);
    end
  end

  assign res = res_r;

endmodule

// ===== rtl/imu_tilt_and_yaw_integrator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_tilt_and_yaw_integrator: six-axis IMU sample conversion
// Rates, accelerations, roll/pitch by CORDIC, integrated yaw, temperature.
// ----------------------------------------------------------------------------
// One sample request is taken at a time. A sample (tuser = 0) occupies the
// block from acceptance until its result enters the output register: the
// accept cycle, the yaw product, the saturating accumulate, unit setup, the
// bit-serial square root (the yaw readout division, roll CORDIC and unit
// scaling run alongside it), the start of pitch, one CORDIC iteration per
// cycle for pitch, and the load of the output register. That load waits for
// as long as the previous result is still held in the output register. A
// clear request (tuser = 1) zeroes yaw in its accept cycle, gives no result,
// and the next request can follow at once. The output register holds a
// result until taken while the next sample is already being worked on. The
// yaw deadzone register sits at byte address 0.
// ----------------------------------------------------------------------------
module imu_tilt_and_yaw_integrator (
  input  logic          clk,
  input  logic          rst_n,
  // input: gyro_x_raw, gyro_y_raw, gyro_z_raw, accel_x_raw, accel_y_raw,
  //        accel_z_raw, temp_raw, elapsed_us
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [143:0]  in_tdata,
  input  logic [0:0]    in_tuser,   // kind: 0 sample, 1 clear yaw
  // output: rate_x, rate_y, rate_z, accel_x_ms2, accel_y_ms2, accel_z_ms2,
  //         roll_angle, pitch_angle, yaw_angle, temperature, zero pad
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [175:0]  out_tdata,
  // register port
  input  logic          cfg_psel,
  input  logic          cfg_penable,
  input  logic          cfg_pwrite,
  input  logic [2:0]    cfg_paddr,
  input  logic [31:0]   cfg_pwdata,
  output logic [31:0]   cfg_prdata,
  output logic          cfg_pready
);
  import imu_pkg::*;

  dp_cmd_t     cmd;
  sample_t     smp;
  result_t     res;
  logic [14:0] deadzone_r;

  // register file: single deadzone register, word index in paddr[2]
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadzone_r <= 15'd16;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_DEADZONE) begin
      deadzone_r <= cfg_pwdata[14:0];
    end
  end
  assign cfg_prdata = (cfg_paddr[2] == REG_DEADZONE) ? {17'b0, deadzone_r} : 32'b0;

  // unpack request
  assign smp.gyro_x_raw  = in_tdata[15:0];
  assign smp.gyro_y_raw  = in_tdata[31:16];
  assign smp.gyro_z_raw  = in_tdata[47:32];
  assign smp.accel_x_raw = in_tdata[63:48];
  assign smp.accel_y_raw = in_tdata[79:64];
  assign smp.accel_z_raw = in_tdata[95:80];
  assign smp.temp_raw    = in_tdata[111:96];
  assign smp.elapsed_us  = in_tdata[143:112];

  imu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_kind    (in_tuser[0]),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  imu_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .smp      (smp),
    .deadzone (deadzone_r),
    .res      (res)
  );

  assign out_tdata = {1'b0, res.temperature, res.yaw_angle, res.pitch_angle,
                      res.roll_angle, res.accel_z_ms2, res.accel_y_ms2,
                      res.accel_x_ms2, res.rate_z, res.rate_y, res.rate_x};

endmodule
